// File: rtl/remote_pan_tilt_relay_controller_assert.svh
`ifndef REMOTE_PAN_TILT_RELAY_CONTROLLER_ASSERT_SVH
`define REMOTE_PAN_TILT_RELAY_CONTROLLER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RPTRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled in reset
`define RPTRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// File: rtl/rptrc_pkg.sv
package rptrc_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CODE_W    = 32;
  localparam int TIME_W    = 32;
  localparam int TILT_W    = 7;
  localparam int PAN_W     = 8;

  localparam logic [CODE_W-1:0] CODE_UP     = 32'd2907897600;
  localparam logic [CODE_W-1:0] CODE_DOWN   = 32'd3877175040;
  localparam logic [CODE_W-1:0] CODE_LEFT   = 32'd4144561920;
  localparam logic [CODE_W-1:0] CODE_RIGHT  = 32'd2774204160;
  localparam logic [CODE_W-1:0] CODE_OK     = 32'd3810328320;
  localparam logic [CODE_W-1:0] CODE_STAR   = 32'd3910598400;
  localparam logic [CODE_W-1:0] CODE_SQUARE = 32'd4061003520;

  localparam logic [TILT_W-1:0] TILT_HOME = 7'd109;
  localparam logic [TILT_W-1:0] TILT_MIN  = 7'd84;
  localparam logic [TILT_W-1:0] TILT_MAX  = 7'd124;

  localparam logic [PAN_W-1:0] PAN_STOP  = 8'd90;
  localparam logic [PAN_W-1:0] PAN_LEFT  = 8'd180;
  localparam logic [PAN_W-1:0] PAN_RIGHT = 8'd0;

  localparam logic [CFG_IDX_W-1:0] REG_RELAY_HOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELAY_EXTEND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_TIMEOUT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_INTERVAL  = 2'd3;

  localparam logic [CFG_W-1:0] RELAY_HOLD_RST   = 16'd500;
  localparam logic [CFG_W-1:0] RELAY_EXTEND_RST = 16'd300;
  localparam logic [CFG_W-1:0] CMD_TIMEOUT_RST  = 16'd200;
  localparam logic [CFG_W-1:0] PAN_INTERVAL_RST = 16'd20;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_UP     = 3'd1,
    CMD_DOWN   = 3'd2,
    CMD_LEFT   = 3'd3,
    CMD_RIGHT  = 3'd4,
    CMD_OK     = 3'd5,
    CMD_STAR   = 3'd6,
    CMD_SQUARE = 3'd7
  } cmd_t;

endpackage

// File: rtl/remote_pan_tilt_relay_controller.sv
// channel | dir | handshake            | word
// in      | in  | in_valid / in_stall  | operation, raw_code, is_repeat
// out     | out | out_valid / out_stall | tilt_angle, pan_angle, relay_one, relay_two
// cfg     | in  | cfg_we               | cfg_index, cfg_wdata
// One word per cycle unless out_stall holds it: an input register, one update pass,
// and the state registers that double as the result register. A stalled result holds
// the state; the input register can still take one more word. rst_n is synchronous,
// active low, and restores all state and config registers, not op_r, code_r, rep_r.
module remote_pan_tilt_relay_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [rptrc_pkg::CODE_W-1:0]    in_raw_code,
  input  logic                            in_is_repeat,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rptrc_pkg::TILT_W-1:0]    out_tilt_angle,
  output logic [rptrc_pkg::PAN_W-1:0]     out_pan_angle,
  output logic                            out_relay_one,
  output logic                            out_relay_two,
  input  logic                            cfg_we,
  input  logic [rptrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rptrc_pkg::CFG_W-1:0]     cfg_wdata
);
  import rptrc_pkg::*;

  logic              in_vld_r;
  logic              op_r;
  logic [CODE_W-1:0] code_r;
  logic              rep_r;
  logic              out_vld_r;

  logic [CFG_W-1:0] hold_ms_r, extend_ms_r, timeout_ms_r, interval_ms_r;

  logic [TIME_W-1:0] now_r, last_frame_r, last_step_r, r1_end_r;
  logic              r1_on_r, r2_on_r, fresh_r;
  logic [TILT_W-1:0] tilt_r;
  logic [PAN_W-1:0]  pan_r, goal_r;
  cmd_t              held_r;

  logic [TIME_W-1:0] now_nxt, last_frame_nxt, last_step_nxt, r1_end_nxt;
  logic              r1_on_nxt, r2_on_nxt, fresh_nxt;
  logic [TILT_W-1:0] tilt_nxt;
  logic [PAN_W-1:0]  pan_nxt, goal_nxt;
  cmd_t              held_nxt;

  logic              advance;
  logic              in_take;
  logic [TIME_W-1:0] now_inc, ext_a, ext_b;

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign out_valid      = out_vld_r;
  assign out_tilt_angle = tilt_r;
  assign out_pan_angle  = pan_r;
  assign out_relay_one  = r1_on_r;
  assign out_relay_two  = r2_on_r;

  assign now_inc = now_r + TIME_W'(1);

  always_comb begin
    now_nxt        = now_r;
    last_frame_nxt = last_frame_r;
    last_step_nxt  = last_step_r;
    r1_end_nxt     = r1_end_r;
    r1_on_nxt      = r1_on_r;
    r2_on_nxt      = r2_on_r;
    fresh_nxt      = fresh_r;
    tilt_nxt       = tilt_r;
    pan_nxt        = pan_r;
    goal_nxt       = goal_r;
    held_nxt       = held_r;
    ext_a          = '0;
    ext_b          = '0;
    if (!op_r) begin
      now_nxt = now_inc;
      if (r1_on_r && (now_inc > r1_end_r)) begin
        r1_on_nxt = 1'b0;
      end
      if ((now_inc - last_frame_r) > TIME_W'(timeout_ms_r)) begin
        goal_nxt = PAN_STOP;
      end
      if ((now_inc - last_step_r) >= TIME_W'(interval_ms_r)) begin
        if (pan_r < goal_nxt) begin
          pan_nxt = pan_r + PAN_W'(1);
        end else if (pan_r > goal_nxt) begin
          pan_nxt = pan_r - PAN_W'(1);
        end
        last_step_nxt = now_inc;
      end
    end else begin
      if (!rep_r) begin
        fresh_nxt = 1'b1;
        case (code_r)
          CODE_UP:     held_nxt = CMD_UP;
          CODE_DOWN:   held_nxt = CMD_DOWN;
          CODE_LEFT: begin
            held_nxt = CMD_LEFT;
            goal_nxt = PAN_LEFT;
          end
          CODE_RIGHT: begin
            held_nxt = CMD_RIGHT;
            goal_nxt = PAN_RIGHT;
          end
          CODE_OK: begin
            held_nxt = CMD_OK;
            if (!r1_on_r) begin
              r1_on_nxt  = 1'b1;
              r1_end_nxt = now_r + TIME_W'(hold_ms_r);
            end
          end
          CODE_STAR:   held_nxt = CMD_STAR;
          CODE_SQUARE: held_nxt = CMD_SQUARE;
          default:     held_nxt = CMD_NONE;
        endcase
      end
      if ((fresh_nxt || rep_r) && (held_nxt != CMD_NONE)) begin
        case (held_nxt)
          CMD_UP: begin
            if (tilt_r < TILT_MAX) begin
              tilt_nxt = tilt_r + TILT_W'(1);
            end
            if (tilt_nxt < TILT_MIN) begin
              tilt_nxt = TILT_MIN;
            end
          end
          CMD_DOWN: begin
            if (tilt_r > TILT_MIN) begin
              tilt_nxt = tilt_r - TILT_W'(1);
            end
            if (tilt_nxt > TILT_MAX) begin
              tilt_nxt = TILT_MAX;
            end
          end
          CMD_OK: begin
            if (r1_on_nxt) begin
              ext_a      = r1_end_nxt + TIME_W'(extend_ms_r);
              ext_b      = now_r + TIME_W'(extend_ms_r);
              r1_end_nxt = (ext_a < ext_b) ? ext_a : ext_b;
            end
          end
          CMD_SQUARE: r2_on_nxt = !r2_on_r;
          CMD_STAR:   tilt_nxt  = TILT_HOME;
          default:    tilt_nxt  = tilt_r;
        endcase
        fresh_nxt = 1'b0;
      end
      last_frame_nxt = now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      hold_ms_r     <= RELAY_HOLD_RST;
      extend_ms_r   <= RELAY_EXTEND_RST;
      timeout_ms_r  <= CMD_TIMEOUT_RST;
      interval_ms_r <= PAN_INTERVAL_RST;
      now_r         <= '0;
      last_frame_r  <= '0;
      last_step_r   <= '0;
      r1_end_r      <= '0;
      r1_on_r       <= 1'b0;
      r2_on_r       <= 1'b0;
      fresh_r       <= 1'b0;
      tilt_r        <= TILT_HOME;
      pan_r         <= PAN_STOP;
      goal_r        <= PAN_STOP;
      held_r        <= CMD_NONE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RELAY_HOLD:   hold_ms_r     <= cfg_wdata;
          REG_RELAY_EXTEND: extend_ms_r   <= cfg_wdata;
          REG_CMD_TIMEOUT:  timeout_ms_r  <= cfg_wdata;
          REG_PAN_INTERVAL: interval_ms_r <= cfg_wdata;
          default:          hold_ms_r     <= hold_ms_r;
        endcase
      end
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (advance) begin
        now_r        <= now_nxt;
        last_frame_r <= last_frame_nxt;
        last_step_r  <= last_step_nxt;
        r1_end_r     <= r1_end_nxt;
        r1_on_r      <= r1_on_nxt;
        r2_on_r      <= r2_on_nxt;
        fresh_r      <= fresh_nxt;
        tilt_r       <= tilt_nxt;
        pan_r        <= pan_nxt;
        goal_r       <= goal_nxt;
        held_r       <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r   <= in_operation;
      code_r <= in_raw_code;
      rep_r  <= in_is_repeat;
    end
  end

`include "remote_pan_tilt_relay_controller_assert.svh"

  `RPTRC_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, in_vld_r && out_vld_r && out_stall)
  `RPTRC_ASSERT_NEXT(a_advance_shows_result, clk, rst_n, advance, out_vld_r)
  `RPTRC_ASSERT_NOW(a_tilt_in_range, clk, rst_n, out_vld_r, (tilt_r >= TILT_MIN) && (tilt_r <= TILT_MAX))
  `RPTRC_ASSERT_NOW(a_pan_in_range, clk, rst_n, out_vld_r, (pan_r <= PAN_LEFT) && (goal_r <= PAN_LEFT))

endmodule
